// ----- hw/rtl/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
package spq_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_WIDTH  = 16;
  localparam int DATA_WIDTH = 16;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_PEEK    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [KEY_WIDTH-1:0]  item_key;
    logic [DATA_WIDTH-1:0] item_payload;
  } in_req_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]  out_key;
    logic [DATA_WIDTH-1:0] out_payload;
    logic [CNT_W-1:0]      entry_count;
    logic [1:0]            status;
  } out_res_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]  key;
    logic [DATA_WIDTH-1:0] payload;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic   ins_en;
    logic   ext_en;
    logic   largest_first;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/spq_cell.sv -----
// one slot of the sorted chain: holds an entry and shifts left or right
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                cell_vld,
  input  logic                placed_in,
  input  spq_pkg::entry_t     left_entry,
  input  spq_pkg::entry_t     right_entry,
  output logic                placed_out,
  output spq_pkg::entry_t     entry
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   new_better;
  logic   flag;

  assign new_better = ctrl.largest_first ? (ctrl.new_entry.key > entry_r.key)
                                         : (ctrl.new_entry.key < entry_r.key);
  // an empty slot always accepts; equal keys keep arrival order
  assign flag       = !cell_vld || new_better;
  assign placed_out = placed_in || flag;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en) begin
      if (placed_in) begin
        entry_nxt = left_entry;
      end else if (flag) begin
        entry_nxt = ctrl.new_entry;
      end
    end else if (ctrl.ext_en) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ----- hw/rtl/sorted_priority_queue_top.sv -----
// sorted priority queue: controller, output register and the chain of cells
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/in_stall   | in_req_t (opcode, key, payload)
//  out_    | output    | out_valid/out_stall | out_res_t (key, payload, count, status)
//  cfg_    | input     | cfg_we              | largest_first bit
//
// every request is served in parallel: all cells compare against the new key at once
// and the result lands in the output register on the accepting edge.
// a new request is taken each cycle while the output register is empty or out_stall is low.
// out_stall holds the result and stalls the input until it is taken.
// reset clears the entry count, the output valid and largest_first.
module sorted_priority_queue_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  spq_pkg::in_req_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output spq_pkg::out_res_t out_data,
  input  logic             cfg_we,
  input  logic             cfg_wdata
);
  import spq_pkg::*;

  logic       largest_first_r;
  logic [CNT_W-1:0] occ_r;
  logic [CNT_W-1:0] occ_nxt;
  logic       out_valid_r;
  out_res_t   out_data_r;
  out_res_t   res_nxt;
  logic       in_acc;
  logic       is_empty;
  logic       is_full;
  cell_ctrl_t ctrl;
  entry_t     cell_entry [CAPACITY];
  logic       placed [CAPACITY+1];

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign is_empty = (occ_r == '0);
  assign is_full  = (occ_r == CNT_W'(CAPACITY));

  always_comb begin
    ctrl.ins_en                = 1'b0;
    ctrl.ext_en                = 1'b0;
    ctrl.largest_first         = largest_first_r;
    ctrl.new_entry.key         = in_data.item_key;
    ctrl.new_entry.payload     = in_data.item_payload;
    res_nxt.out_key     = '0;
    res_nxt.out_payload = '0;
    res_nxt.status      = ST_OK;
    occ_nxt             = occ_r;
    case (opcode_t'(in_data.opcode))
      OP_INSERT: begin
        if (is_full) begin
          res_nxt.status = ST_FULL;
        end else begin
          ctrl.ins_en = in_acc;
          occ_nxt     = occ_r + CNT_W'(1);
        end
      end
      OP_EXTRACT, OP_PEEK: begin
        if (is_empty) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          res_nxt.out_key     = cell_entry[0].key;
          res_nxt.out_payload = cell_entry[0].payload;
          if (opcode_t'(in_data.opcode) == OP_EXTRACT) begin
            ctrl.ext_en = in_acc;
            occ_nxt     = occ_r - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    res_nxt.entry_count = occ_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      largest_first_r <= 1'b0;
      occ_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        largest_first_r <= cfg_wdata;
      end
      if (in_acc) begin
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // insertion point ripples from the head toward the tail
  assign placed[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    if (i == 0) begin : g_head
      assign left_e = cell_entry[0];
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = cell_entry[i];
    end else begin : g_body
      assign right_e = cell_entry[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .cell_vld    (occ_r > CNT_W'(i)),
      .placed_in   (placed[i]),
      .left_entry  (left_e),
      .right_entry (right_e),
      .placed_out  (placed[i+1]),
      .entry       (cell_entry[i])
    );
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted request produced no result");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.entry_count == occ_r))
    else $error("reported count differs from stored count");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.opcode == OP_INSERT && is_full) |=>
      (occ_r == $past(occ_r) && out_data_r.status == ST_FULL))
    else $error("insert into full queue was not dropped");

endmodule
